@@ sv/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// No dependencies; imported by the decode stage, result queue and top level.

package u8u16_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
   localparam logic [15:0] HI_SURR     = 16'hD800;
   localparam logic [15:0] LO_SURR     = 16'hDC00;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
   localparam logic [20:0] CP_MAX      = 21'h10FFFD;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [1:0]  CONT_TAG    = 2'b10;

   // Lead nibbles that open a multi-byte sequence
   localparam logic [3:0]  LEAD2_A     = 4'hC;
   localparam logic [3:0]  LEAD2_B     = 4'hD;
   localparam logic [3:0]  LEAD3       = 4'hE;
   localparam logic [3:0]  LEAD4       = 4'hF;

   localparam logic [7:0]  MASK_LEAD2  = 8'h1F;
   localparam logic [7:0]  MASK_LEAD3  = 8'h0F;
   localparam logic [7:0]  MASK_LEAD4  = 8'h07;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic        end_of_string;
      logic [15:0] total_units;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [20:0] partial_code;
      logic [1:0]  bytes_remaining;
      logic [15:0] unit_count;
   } state_type;

   typedef struct packed {
      logic [1:0] n_results;
      result_type r0;
      result_type r1;
      state_type  next;
   } decode_type;

   function automatic logic [15:0] sat_inc(logic [15:0] c, logic v);
      return (v && (c != COUNT_MAX)) ? c + 16'd1 : c;
   endfunction

endpackage

@@ sv/u8u16_decode.sv @@
// Combinational decode of one byte against the current sequence state.
// Produces up to two results and the next state. Depends on u8u16_pkg.

module u8u16_decode (
   input  logic [7:0]            in_byte,
   input  u8u16_pkg::state_type  state,
   output u8u16_pkg::decode_type dec
);
   import u8u16_pkg::*;

   logic        is_cont;
   logic        pending;
   logic        lead_emit;
   logic [15:0] lead_code;
   logic [20:0] lead_pc;
   logic [1:0]  lead_rem;
   logic [20:0] pc_shift;
   logic [1:0]  rem_dec;
   logic [20:0] supp;
   logic [15:0] u0_code, u1_code;
   logic        u0_valid, u1_valid, u0_eos;
   logic [1:0]  n;
   logic [20:0] next_pc;
   logic [1:0]  next_rem;
   logic [15:0] tot0, tot1;

   assign is_cont  = (in_byte[7:6] == CONT_TAG);
   assign pending  = (state.bytes_remaining != 2'd0);
   assign pc_shift = {state.partial_code[14:0], in_byte[5:0]};
   assign rem_dec  = state.bytes_remaining - 2'd1;
   assign supp     = pc_shift - SUPP_BASE;

   always_comb begin
      lead_rem = 2'd0;
      lead_pc  = '0;
      case (in_byte[7:4])
         LEAD2_A, LEAD2_B: begin
            lead_rem = 2'd1;
            lead_pc  = {13'd0, in_byte & MASK_LEAD2};
         end
         LEAD3: begin
            lead_rem = 2'd2;
            lead_pc  = {13'd0, in_byte & MASK_LEAD3};
         end
         LEAD4: begin
            lead_rem = 2'd3;
            lead_pc  = {13'd0, in_byte & MASK_LEAD4};
         end
         default: begin
            lead_rem = 2'd0;
            lead_pc  = '0;
         end
      endcase
   end

   // A stray continuation or a single-byte code emits straight away
   assign lead_emit = is_cont || (lead_rem == 2'd0);
   assign lead_code = is_cont ? REPL_UNIT : {8'h00, in_byte};

   always_comb begin
      n        = 2'd0;
      u0_code  = '0;
      u0_valid = 1'b1;
      u0_eos   = 1'b0;
      u1_code  = '0;
      u1_valid = 1'b1;
      next_pc  = state.partial_code;
      next_rem = state.bytes_remaining;
      if (in_byte == 8'h00) begin
         n        = 2'd1;
         u0_code  = pending ? REPL_UNIT : 16'h0000;
         u0_valid = pending;
         u0_eos   = 1'b1;
         next_pc  = '0;
         next_rem = 2'd0;
      end else if (pending) begin
         if (is_cont) begin
            next_pc  = pc_shift;
            next_rem = rem_dec;
            if (rem_dec == 2'd0) begin
               next_pc = '0;
               if (pc_shift <= BMP_MAX) begin
                  n       = 2'd1;
                  u0_code = pc_shift[15:0];
               end else if (pc_shift <= CP_MAX) begin
                  n       = 2'd2;
                  u0_code = HI_SURR | {6'd0, supp[19:10]};
                  u1_code = LO_SURR | {6'd0, supp[9:0]};
               end else begin
                  n       = 2'd1;
                  u0_code = REPL_UNIT;
               end
            end
         end else begin
            // interrupted sequence: replacement, then the byte as a new lead
            u0_code  = REPL_UNIT;
            u1_code  = lead_code;
            n        = lead_emit ? 2'd2 : 2'd1;
            next_pc  = lead_pc;
            next_rem = lead_rem;
         end
      end else begin
         u0_code  = lead_code;
         n        = lead_emit ? 2'd1 : 2'd0;
         next_pc  = lead_pc;
         next_rem = lead_rem;
      end
   end

   assign tot0 = sat_inc(state.unit_count, u0_valid);
   assign tot1 = sat_inc(tot0, u1_valid);

   always_comb begin
      dec.n_results        = n;
      dec.r0.code_unit     = u0_code;
      dec.r0.unit_valid    = u0_valid;
      dec.r0.end_of_string = u0_eos;
      dec.r0.total_units   = tot0;
      dec.r0.last          = (n == 2'd1);
      dec.r1.code_unit     = u1_code;
      dec.r1.unit_valid    = u1_valid;
      dec.r1.end_of_string = 1'b0;
      dec.r1.total_units   = tot1;
      dec.r1.last          = (n == 2'd2);
      dec.next.partial_code    = next_pc;
      dec.next.bytes_remaining = next_rem;
      if (u0_eos) begin
         dec.next.unit_count = '0;
      end else begin
         case (n)
            2'd1:    dec.next.unit_count = tot0;
            2'd2:    dec.next.unit_count = tot1;
            default: dec.next.unit_count = state.unit_count;
         endcase
      end
   end

endmodule

@@ sv/u8u16_result_queue.sv @@
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on u8u16_pkg for the result record.

module u8u16_result_queue #(
   parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  u8u16_pkg::result_type push0,
   input  u8u16_pkg::result_type push1,
   input  logic                  pop,
   output u8u16_pkg::result_type head,
   output logic                  not_empty,
   output logic                  room_for_two
);
   import u8u16_pkg::*;

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] TWO_SHORT = CNT_W'(DEPTH - 2);

   result_type       entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;

   function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_next  = step_ptr(wr_ptr_ff);
   assign head         = entries_ff[rd_ptr_ff];
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= TWO_SHORT);

   always_comb begin
      case (push_n)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = step_ptr(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? step_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_next] <= push1;
      end
   end

endmodule

@@ sv/utf8_to_utf16_stream_decoder_unit.sv @@
// Top level of the UTF-8 to UTF-16 stream decoder.
// Uses u8u16_pkg, u8u16_decode and u8u16_result_queue.
//
// Usage:
//  - req_ channel carries one UTF-8 byte per transaction (req_in_byte); a zero
//    byte ends the string. rsp_ channel returns UTF-16 code units, each with
//    unit_valid, end_of_string, the running saturated unit count and a last
//    flag marking the final result caused by a byte.
//  - A byte gives zero, one or two results. The byte is decoded in the cycle
//    it is taken and its results appear on rsp_ in the next cycle at the
//    earliest. A second result follows the first, in order.
//  - Throughput: one byte per cycle while bytes give at most one result and
//    rsp_ is not stalled; two-result bytes are limited by the rsp_ side to one result a cycle.
//  - req_stall rises when the result queue (QUEUE_DEPTH entries, at least 2)
//    cannot take two more results; it depends only on queue occupancy.
//  - A stalled rsp_ side holds its transaction; bytes keep flowing until the
//    queue has room for fewer than two more results.
//  - Reset clears the sequence state, the unit count and the queue.

module utf8_to_utf16_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_unit_valid,
   output logic        rsp_end_of_string,
   output logic [15:0] rsp_total_units,
   output logic        rsp_last
);
   import u8u16_pkg::*;

   state_type  state_ff, state_in;
   decode_type dec;
   result_type head;
   logic       req_accept;
   logic       rsp_accept;
   logic       room_for_two;
   logic [1:0] push_n;

   assign req_stall  = !room_for_two;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign push_n     = req_accept ? dec.n_results : 2'd0;
   assign state_in   = req_accept ? dec.next : state_ff;

   u8u16_decode u_decode (
      .in_byte (req_in_byte),
      .state   (state_ff),
      .dec     (dec)
   );

   u8u16_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_n       (push_n),
      .push0        (dec.r0),
      .push1        (dec.r1),
      .pop          (rsp_accept),
      .head         (head),
      .not_empty    (rsp_valid),
      .room_for_two (room_for_two)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_code_unit     = head.code_unit;
   assign rsp_unit_valid    = head.unit_valid;
   assign rsp_end_of_string = head.end_of_string;
   assign rsp_total_units   = head.total_units;
   assign rsp_last          = head.last;

   // second result of a byte is always a low surrogate or a unit after a replacement
   a_pair_second_valid: assert property (@(posedge clock) disable iff (reset)
      (req_accept && dec.n_results == 2'd2) |-> (dec.r1.unit_valid && dec.r1.last
         && !dec.r0.last))
      else $error("two-result transaction with malformed second result");

   a_eos_alone: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_in_byte == 8'h00) |=>
         (state_ff.unit_count == 16'd0 && state_ff.bytes_remaining == 2'd0))
      else $error("end of string did not clear decoder state");

   a_stall_means_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with an empty result queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending straight after reset");

endmodule
